/* hdl/rlsp_pkg.sv */
// Shared types, constants and saturation helpers of the RLS predictor.
// Used by the arithmetic unit and the top level; depends on nothing.
`default_nettype none
package rlsp_pkg;

  localparam int SMP_W   = 24;  // samples, Q4.20
  localparam int WGT_W   = 32;  // weights, Q8.24
  localparam int MAT_W   = 40;  // matrix and gain, Q16.24
  localparam int ACC_W   = 48;  // sums and denominator
  localparam int FF_W    = 17;  // forgetting factor, Q1.16
  localparam int RES_W   = 64;  // signed ratio result
  localparam int PROD_W  = 80;  // full product magnitude
  localparam int DIGIT_W = 8;   // multiplier digit per cycle
  localparam int MUL_DIGITS = MAT_W / DIGIT_W;

  localparam logic [FF_W-1:0]         LAM_ONE     = 17'd65536;
  localparam logic signed [MAT_W-1:0] P_ONE       = 40'sd16777216;
  localparam logic signed [WGT_W-1:0] W_ONE       = 32'sd16777216;
  localparam logic signed [WGT_W-1:0] W_TWO       = 32'sd33554432;
  localparam logic signed [WGT_W-1:0] W_MINUS_ONE = -32'sd16777216;
  localparam logic signed [MAT_W-1:0] LAM_SCALE   = 40'sd65536;
  localparam logic [RES_W-1:0]        RATIO_CAP   = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {
    RM_SHIFT20 = 2'd0,
    RM_SHIFT24 = 2'd1,
    RM_DIV     = 2'd2
  } ratio_mode_e;

  // One request to the shared product-and-quotient unit.
  typedef struct packed {
    logic signed [MAT_W-1:0] a;
    logic signed [MAT_W-1:0] b;
    logic signed [ACC_W-1:0] d;
    ratio_mode_e             mode;
  } ratio_req_t;

  function automatic logic signed [MAT_W-1:0] sat40(input logic signed [RES_W-1:0] v);
    logic signed [MAT_W-1:0] r;
    if (v > 64'sd549755813887) begin
      r = 40'sh7F_FFFF_FFFF;
    end else if (v < -64'sd549755813888) begin
      r = 40'sh80_0000_0000;
    end else begin
      r = v[MAT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WGT_W-1:0] sat32(input logic signed [RES_W-1:0] v);
    logic signed [WGT_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[WGT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SMP_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > 48'sd8388607) begin
      r = 24'sh7F_FFFF;
    end else if (v < -48'sd8388608) begin
      r = 24'sh80_0000;
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/rlsp_if.sv */
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on nothing.
`default_nettype none
interface rlsp_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rlsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] next_prediction;
  logic signed [23:0] prior_error;
  logic               adapted;
  logic               ready_res;
  modport source (output valid, output next_prediction, output prior_error,
                  output adapted, output ready_res, input ready);
  modport sink (input valid, input next_prediction, input prior_error,
                input adapted, input ready_res, output ready);
endinterface
`default_nettype wire

/* hdl/rlsp_cell.sv */
// One storage cell of a circular chain: loads its neighbor's word on shift.
// Depends on nothing.
`default_nettype none
module rlsp_cell #(
  parameter int              WIDTH   = 8,
  parameter logic [WIDTH-1:0] RST_VAL = '0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             shift_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic      [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q, data_d;

  assign data_d = shift_i ? data_i : data_q;
  assign data_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= RST_VAL;
    end else begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/rlsp_ratio.sv */
// Shared unit for trunc(a*b/d), magnitude limited to 2^62: an 8-bit-digit
// multiplier followed by a restoring divider or a fixed shift. Uses rlsp_pkg.
`default_nettype none
module rlsp_ratio (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire rlsp_pkg::ratio_req_t  req_i,
  output logic                       done_o,
  output logic signed [rlsp_pkg::RES_W-1:0] res_o
);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_MUL  = 4'b0010,
    R_DIV  = 4'b0100,
    R_FIN  = 4'b1000
  } rat_state_e;

  rat_state_e                         st_q, st_d;
  logic [rlsp_pkg::MAT_W-1:0]         ma_q, ma_d, mb_q, mb_d;
  logic [rlsp_pkg::ACC_W-1:0]         md_q, md_d, rem_q, rem_d;
  logic                               neg_q, neg_d;
  rlsp_pkg::ratio_mode_e              mode_q, mode_d;
  logic [6:0]                         cnt_q, cnt_d;
  logic [rlsp_pkg::PROD_W-1:0]        prod_q, prod_d;

  logic [rlsp_pkg::MAT_W-1:0]         a_mag, b_mag;
  logic [rlsp_pkg::ACC_W-1:0]         d_mag;
  logic [rlsp_pkg::MAT_W+rlsp_pkg::DIGIT_W-1:0] pp;
  logic [rlsp_pkg::PROD_W-1:0]        prod_sum;
  logic [rlsp_pkg::ACC_W:0]           rem_sh;
  logic                               ge;
  logic [rlsp_pkg::RES_W-1:0]         qcap;

  assign a_mag = req_i.a[rlsp_pkg::MAT_W-1] ? rlsp_pkg::MAT_W'(-req_i.a) : req_i.a;
  assign b_mag = req_i.b[rlsp_pkg::MAT_W-1] ? rlsp_pkg::MAT_W'(-req_i.b) : req_i.b;
  assign d_mag = req_i.d[rlsp_pkg::ACC_W-1] ? rlsp_pkg::ACC_W'(-req_i.d) : req_i.d;

  // Digits enter most significant first, so the running sum shifts up a digit.
  assign pp       = ma_q * mb_q[rlsp_pkg::MAT_W-1 -: rlsp_pkg::DIGIT_W];
  assign prod_sum = {prod_q[rlsp_pkg::PROD_W-rlsp_pkg::DIGIT_W-1:0], {rlsp_pkg::DIGIT_W{1'b0}}}
                    + rlsp_pkg::PROD_W'(pp);

  assign rem_sh = {rem_q, prod_q[rlsp_pkg::PROD_W-1]};
  assign ge     = (rem_sh >= {1'b0, md_q});

  assign qcap  = (prod_q > rlsp_pkg::PROD_W'(rlsp_pkg::RATIO_CAP)) ?
                 rlsp_pkg::RATIO_CAP : prod_q[rlsp_pkg::RES_W-1:0];
  assign res_o = neg_q ? -signed'(qcap) : signed'(qcap);
  assign done_o = (st_q == R_FIN);

  always_comb begin
    st_d   = st_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    md_d   = md_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    case (st_q)
      R_IDLE: begin
        if (start_i) begin
          ma_d   = a_mag;
          mb_d   = b_mag;
          md_d   = d_mag;
          mode_d = req_i.mode;
          neg_d  = req_i.a[rlsp_pkg::MAT_W-1] ^ req_i.b[rlsp_pkg::MAT_W-1] ^
                   ((req_i.mode == rlsp_pkg::RM_DIV) && req_i.d[rlsp_pkg::ACC_W-1]);
          prod_d = '0;
          cnt_d  = '0;
          st_d   = R_MUL;
        end
      end
      R_MUL: begin
        prod_d = prod_sum;
        mb_d   = mb_q << rlsp_pkg::DIGIT_W;
        cnt_d  = cnt_q + 7'd1;
        if (cnt_q == 7'(rlsp_pkg::MUL_DIGITS - 1)) begin
          cnt_d = '0;
          rem_d = '0;
          case (mode_q)
            rlsp_pkg::RM_DIV: begin
              st_d = R_DIV;
            end
            rlsp_pkg::RM_SHIFT24: begin
              prod_d = prod_sum >> 24;
              st_d   = R_FIN;
            end
            default: begin
              prod_d = prod_sum >> 20;
              st_d   = R_FIN;
            end
          endcase
        end
      end
      R_DIV: begin
        rem_d  = ge ? rlsp_pkg::ACC_W'(rem_sh - {1'b0, md_q}) : rem_sh[rlsp_pkg::ACC_W-1:0];
        prod_d = {prod_q[rlsp_pkg::PROD_W-2:0], ge};
        cnt_d  = cnt_q + 7'd1;
        if (cnt_q == 7'(rlsp_pkg::PROD_W - 1)) begin
          st_d = R_FIN;
        end
      end
      R_FIN: begin
        st_d = R_IDLE;
      end
      default: begin
        st_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= R_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    md_q   <= md_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    mode_q <= mode_d;
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
  end

endmodule
`default_nettype wire

/* hdl/rls_adaptive_predictor.sv */
// Recursive-least-squares adaptive linear predictor, top level.
// Input channel smp_i carries one Q4.20 sample per item; output channel res_o
// returns one result item per sample: next_prediction, prior_error, adapted
// and ready_res. The user must write the forgetting factor (Q1.16, 65536
// is 1.0) via cfg_we_i/cfg_wdata_i only while the block is idle; unenforced.
// State lives in circular chains of cells (history, weights, gain, and the
// inverse-correlation matrix in row order) that rotate one word per step past
// a single shared product-and-quotient unit.
// While the history fills, an item only shifts its sample into the history;
// the sample that completes the history also forms a prediction. Afterwards
// an item forms the gain, the denominator, the matrix update, the prior error,
// the weights, the history shift and the prediction in turn, all through the
// shared unit, two quotients per matrix entry: by the denominator and lambda.
// One item is in work at a time; smp_i.ready is high only while idle.
// The finished result waits in an output register, so a new sample is taken
// while the receiver stalls; the block then holds before writing the next one.
// Reset: weights to 2.0, -1.0, then zeros (1.0 when ORDER is 1), matrix to
// identity, history empty, forgetting factor 1.0.
`default_nettype none
module rls_adaptive_predictor #(
  parameter int ORDER = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  rlsp_in_if.sink                          smp_i,
  rlsp_out_if.source                       res_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [rlsp_pkg::FF_W-1:0]   cfg_wdata_i
);

  localparam int NP = ORDER * ORDER;
  localparam int IW = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int CW = $clog2(2 * ORDER);
  localparam int LW = $clog2(ORDER + 1);
  localparam int KF = (ORDER > 1) ? 1 : 0;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_K    = 10'b00_0000_0010,
    ST_D    = 10'b00_0000_0100,
    ST_PP1  = 10'b00_0000_1000,
    ST_PP2  = 10'b00_0001_0000,
    ST_PE   = 10'b00_0010_0000,
    ST_PW   = 10'b00_0100_0000,
    ST_PUSH = 10'b00_1000_0000,
    ST_PF   = 10'b01_0000_0000,
    ST_DONE = 10'b10_0000_0000
  } state_e;

  state_e                              state_q, state_d;
  logic                                pending_q, pending_d;
  logic [IW-1:0]                       i_q, i_d, j_q, j_d;
  logic [CW-1:0]                       c_q, c_d;
  logic [LW-1:0]                       loaded_q, loaded_d;
  logic signed [rlsp_pkg::ACC_W-1:0]   acc_q, acc_d, denom_q, denom_d;
  logic signed [rlsp_pkg::MAT_W-1:0]   diff_q, diff_d, ki_q, ki_d, kn_q, kn_d;
  logic signed [rlsp_pkg::SMP_W-1:0]   err_q, err_d, pred_q, pred_d, smp_q, smp_d;
  logic                                adapt_q, adapt_d, rdy_q, rdy_d;
  logic [rlsp_pkg::FF_W-1:0]           ff_q, ff_d, lam;

  logic                                ov_q, ov_d, oad_q, oad_d, ordy_q, ordy_d;
  logic signed [rlsp_pkg::SMP_W-1:0]   onp_q, onp_d, oerr_q, oerr_d;

  // Cell chains.
  logic [rlsp_pkg::MAT_W-1:0]  p_q [NP];
  logic [rlsp_pkg::MAT_W-1:0]  p_nb [NP];
  logic [rlsp_pkg::MAT_W-1:0]  k_q [ORDER];
  logic [rlsp_pkg::MAT_W-1:0]  k_nb [ORDER];
  logic [rlsp_pkg::WGT_W-1:0]  w_q [ORDER];
  logic [rlsp_pkg::WGT_W-1:0]  w_nb [ORDER];
  logic [rlsp_pkg::SMP_W-1:0]  x_q [ORDER];
  logic [rlsp_pkg::SMP_W-1:0]  x_nb [ORDER];
  logic                        p_sh, k_sh, w_sh, x_sh;
  logic [rlsp_pkg::MAT_W-1:0]  p_tail, k_tail;
  logic [rlsp_pkg::WGT_W-1:0]  w_tail;
  logic [rlsp_pkg::SMP_W-1:0]  x_tail;

  logic signed [rlsp_pkg::MAT_W-1:0] p_head, k_head, w_head40, x_head40, err16;
  logic signed [rlsp_pkg::ACC_W-1:0] acc_sum;

  rlsp_pkg::ratio_req_t               req;
  logic                               rat_start, rat_done;
  logic signed [rlsp_pkg::RES_W-1:0]  rat_res;

  for (genvar c = 0; c < NP; c++) begin : g_p
    localparam logic [rlsp_pkg::MAT_W-1:0] RV =
      (c % (ORDER + 1) == 0) ? rlsp_pkg::P_ONE : '0;
    if (c == NP - 1) begin : g_end
      assign p_nb[c] = p_tail;
    end else begin : g_mid
      assign p_nb[c] = p_q[c+1];
    end
    rlsp_cell #(.WIDTH(rlsp_pkg::MAT_W), .RST_VAL(RV)) u_cell (
      .clk_i, .rst_ni, .shift_i(p_sh), .data_i(p_nb[c]), .data_o(p_q[c])
    );
  end

  for (genvar c = 0; c < ORDER; c++) begin : g_v
    localparam logic [rlsp_pkg::WGT_W-1:0] WRV =
      (c == 0) ? ((ORDER == 1) ? rlsp_pkg::W_ONE : rlsp_pkg::W_TWO) :
      ((c == 1) ? rlsp_pkg::W_MINUS_ONE : '0);
    if (c == ORDER - 1) begin : g_end
      assign k_nb[c] = k_tail;
      assign w_nb[c] = w_tail;
      assign x_nb[c] = x_tail;
    end else begin : g_mid
      assign k_nb[c] = k_q[c+1];
      assign w_nb[c] = w_q[c+1];
      assign x_nb[c] = x_q[c+1];
    end
    rlsp_cell #(.WIDTH(rlsp_pkg::MAT_W), .RST_VAL('0)) u_kcell (
      .clk_i, .rst_ni, .shift_i(k_sh), .data_i(k_nb[c]), .data_o(k_q[c])
    );
    rlsp_cell #(.WIDTH(rlsp_pkg::WGT_W), .RST_VAL(WRV)) u_wcell (
      .clk_i, .rst_ni, .shift_i(w_sh), .data_i(w_nb[c]), .data_o(w_q[c])
    );
    rlsp_cell #(.WIDTH(rlsp_pkg::SMP_W), .RST_VAL('0)) u_xcell (
      .clk_i, .rst_ni, .shift_i(x_sh), .data_i(x_nb[c]), .data_o(x_q[c])
    );
  end

  rlsp_ratio u_ratio (
    .clk_i, .rst_ni, .start_i(rat_start), .req_i(req), .done_o(rat_done), .res_o(rat_res)
  );

  assign p_head   = signed'(p_q[0]);
  assign k_head   = signed'(k_q[0]);
  assign w_head40 = {{8{w_q[0][rlsp_pkg::WGT_W-1]}}, w_q[0]};
  assign x_head40 = {{16{x_q[0][rlsp_pkg::SMP_W-1]}}, x_q[0]};
  assign err16    = {{12{err_q[rlsp_pkg::SMP_W-1]}}, err_q, 4'b0000};
  assign acc_sum  = acc_q + rat_res[rlsp_pkg::ACC_W-1:0];

  always_comb begin
    if (ff_q == '0) begin
      lam = rlsp_pkg::FF_W'(1);
    end else if (ff_q > rlsp_pkg::LAM_ONE) begin
      lam = rlsp_pkg::LAM_ONE;
    end else begin
      lam = ff_q;
    end
  end

  assign smp_i.ready           = (state_q == ST_IDLE);
  assign res_o.valid           = ov_q;
  assign res_o.next_prediction = onp_q;
  assign res_o.prior_error     = oerr_q;
  assign res_o.adapted         = oad_q;
  assign res_o.ready_res       = ordy_q;

  always_comb begin
    state_d   = state_q;
    pending_d = pending_q;
    i_d       = i_q;
    j_d       = j_q;
    c_d       = c_q;
    loaded_d  = loaded_q;
    acc_d     = acc_q;
    denom_d   = denom_q;
    diff_d    = diff_q;
    ki_d      = ki_q;
    kn_d      = kn_q;
    err_d     = err_q;
    pred_d    = pred_q;
    smp_d     = smp_q;
    adapt_d   = adapt_q;
    rdy_d     = rdy_q;
    ff_d      = cfg_we_i ? cfg_wdata_i : ff_q;
    ov_d      = (ov_q && res_o.ready) ? 1'b0 : ov_q;
    onp_d     = onp_q;
    oerr_d    = oerr_q;
    oad_d     = oad_q;
    ordy_d    = ordy_q;
    p_sh      = 1'b0;
    k_sh      = 1'b0;
    w_sh      = 1'b0;
    x_sh      = 1'b0;
    p_tail    = p_q[0];
    k_tail    = k_q[0];
    w_tail    = w_q[0];
    x_tail    = x_q[0];
    rat_start = 1'b0;
    req       = '0;
    req.mode  = rlsp_pkg::RM_SHIFT20;

    case (state_q)
      ST_IDLE: begin
        if (smp_i.valid) begin
          smp_d   = smp_i.sample;
          adapt_d = (loaded_q == LW'(ORDER));
          i_d     = '0;
          j_d     = '0;
          c_d     = '0;
          acc_d   = '0;
          err_d   = '0;
          pred_d  = '0;
          state_d = (loaded_q == LW'(ORDER)) ? ST_K : ST_PUSH;
        end
      end
      // Gain vector: k_i = sum over j of P_ij * x_j.
      ST_K: begin
        req.a = p_head;
        req.b = x_head40;
        if (!pending_q) begin
          rat_start = 1'b1;
          pending_d = 1'b1;
        end else if (rat_done) begin
          pending_d = 1'b0;
          acc_d     = acc_sum;
          p_sh      = 1'b1;
          x_sh      = 1'b1;
          if (j_q == IW'(ORDER - 1)) begin
            k_sh   = 1'b1;
            k_tail = rlsp_pkg::sat40({{16{acc_sum[rlsp_pkg::ACC_W-1]}}, acc_sum});
            j_d    = '0;
            acc_d  = '0;
            if (i_q == IW'(ORDER - 1)) begin
              i_d     = '0;
              acc_d   = rlsp_pkg::ACC_W'(lam) << 8;
              state_d = ST_D;
            end else begin
              i_d = i_q + IW'(1);
            end
          end else begin
            j_d = j_q + IW'(1);
          end
        end
      end
      ST_D: begin
        req.a = x_head40;
        req.b = k_head;
        if (!pending_q) begin
          rat_start = 1'b1;
          pending_d = 1'b1;
        end else if (rat_done) begin
          pending_d = 1'b0;
          acc_d     = acc_sum;
          x_sh      = 1'b1;
          k_sh      = 1'b1;
          if (i_q == IW'(ORDER - 1)) begin
            denom_d = (acc_sum == '0) ? rlsp_pkg::ACC_W'(1) : acc_sum;
            // The chain rotates back to k_0 on this edge.
            ki_d    = signed'(k_q[KF]);
            kn_d    = signed'(k_q[KF]);
            i_d     = '0;
            j_d     = '0;
            state_d = ST_PP1;
          end else begin
            i_d = i_q + IW'(1);
          end
        end
      end
      // Matrix entry, first half: P_ij - k_i*k_j/denominator.
      ST_PP1: begin
        req.a    = ki_q;
        req.b    = k_head;
        req.d    = denom_q;
        req.mode = rlsp_pkg::RM_DIV;
        if (!pending_q) begin
          rat_start = 1'b1;
          pending_d = 1'b1;
        end else if (rat_done) begin
          pending_d = 1'b0;
          diff_d    = rlsp_pkg::sat40({{24{p_head[rlsp_pkg::MAT_W-1]}}, p_head} - rat_res);
          // Pick up the gain element for the next row as it passes the head.
          if ({1'b0, j_q} == ({1'b0, i_q} + (IW + 1)'(1))) begin
            kn_d = k_head;
          end
          state_d = ST_PP2;
        end
      end
      // Second half: divide by lambda and write the entry at the tail.
      ST_PP2: begin
        req.a    = diff_q;
        req.b    = rlsp_pkg::LAM_SCALE;
        req.d    = rlsp_pkg::ACC_W'(lam);
        req.mode = rlsp_pkg::RM_DIV;
        if (!pending_q) begin
          rat_start = 1'b1;
          pending_d = 1'b1;
        end else if (rat_done) begin
          pending_d = 1'b0;
          p_sh      = 1'b1;
          p_tail    = rlsp_pkg::sat40(rat_res);
          k_sh      = 1'b1;
          state_d   = ST_PP1;
          if (j_q == IW'(ORDER - 1)) begin
            j_d  = '0;
            ki_d = kn_q;
            if (i_q == IW'(ORDER - 1)) begin
              i_d     = '0;
              acc_d   = '0;
              state_d = ST_PE;
            end else begin
              i_d = i_q + IW'(1);
            end
          end else begin
            j_d = j_q + IW'(1);
          end
        end
      end
      ST_PE, ST_PF: begin
        req.a    = w_head40;
        req.b    = x_head40;
        req.mode = rlsp_pkg::RM_SHIFT24;
        if (!pending_q) begin
          rat_start = 1'b1;
          pending_d = 1'b1;
        end else if (rat_done) begin
          pending_d = 1'b0;
          acc_d     = acc_sum;
          w_sh      = 1'b1;
          x_sh      = 1'b1;
          if (i_q == IW'(ORDER - 1)) begin
            i_d = '0;
            if (state_q == ST_PE) begin
              err_d   = rlsp_pkg::sat24({{24{smp_q[rlsp_pkg::SMP_W-1]}}, smp_q} - acc_sum);
              state_d = ST_PW;
            end else begin
              pred_d  = rlsp_pkg::sat24(acc_sum);
              state_d = ST_DONE;
            end
          end else begin
            i_d = i_q + IW'(1);
          end
        end
      end
      ST_PW: begin
        req.a    = k_head;
        req.b    = err16;
        req.d    = denom_q;
        req.mode = rlsp_pkg::RM_DIV;
        if (!pending_q) begin
          rat_start = 1'b1;
          pending_d = 1'b1;
        end else if (rat_done) begin
          pending_d = 1'b0;
          w_sh      = 1'b1;
          w_tail    = rlsp_pkg::sat32({{32{w_q[0][rlsp_pkg::WGT_W-1]}}, w_q[0]} + rat_res);
          k_sh      = 1'b1;
          if (i_q == IW'(ORDER - 1)) begin
            i_d     = '0;
            c_d     = '0;
            state_d = ST_PUSH;
          end else begin
            i_d = i_q + IW'(1);
          end
        end
      end
      // Bring the oldest sample to the head, drop it for the new one, and
      // rotate the new sample around to the head.
      ST_PUSH: begin
        x_sh = 1'b1;
        if (c_q == CW'(ORDER - 1)) begin
          x_tail = smp_q;
        end
        if (c_q == CW'(2 * ORDER - 2)) begin
          if (loaded_q < LW'(ORDER)) begin
            loaded_d = loaded_q + LW'(1);
          end
          i_d   = '0;
          acc_d = '0;
          if (loaded_q >= LW'(ORDER - 1)) begin
            rdy_d   = 1'b1;
            state_d = ST_PF;
          end else begin
            rdy_d   = 1'b0;
            state_d = ST_DONE;
          end
        end else begin
          c_d = c_q + CW'(1);
        end
      end
      ST_DONE: begin
        if (!ov_q || res_o.ready) begin
          ov_d    = 1'b1;
          onp_d   = pred_q;
          oerr_d  = err_q;
          oad_d   = adapt_q;
          ordy_d  = rdy_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pending_q <= 1'b0;
      loaded_q  <= '0;
      ff_q      <= rlsp_pkg::LAM_ONE;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      loaded_q  <= loaded_d;
      ff_q      <= ff_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    c_q     <= c_d;
    acc_q   <= acc_d;
    denom_q <= denom_d;
    diff_q  <= diff_d;
    ki_q    <= ki_d;
    kn_q    <= kn_d;
    err_q   <= err_d;
    pred_q  <= pred_d;
    smp_q   <= smp_d;
    adapt_q <= adapt_d;
    rdy_q   <= rdy_d;
    onp_q   <= onp_d;
    oerr_q  <= oerr_d;
    oad_q   <= oad_d;
    ordy_q  <= ordy_d;
  end

endmodule
`default_nettype wire
